FILE: hdl/can_mbx_pkg.sv
// Package for the CAN receive mailbox table: request, result and entry types,
// command and status structs between controller and datapath, codes and helpers.
// Depends on nothing; every other file of the block imports it.
package can_mbx_pkg;

    localparam int MAILBOX_COUNT = 64;
    localparam int CHANNEL_COUNT = 4;
    localparam int IDX_W = (MAILBOX_COUNT > 1) ? $clog2(MAILBOX_COUNT) : 1;
    localparam int CNT_W = $clog2(MAILBOX_COUNT + 1);
    localparam int SLOT_W = 7;

    localparam logic [10:0] DROP_ID = 11'd701;

    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_FRAME = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] ST_NODATA = 2'd0;
    localparam logic [1:0] ST_NEW    = 2'd1;
    localparam logic [1:0] ST_OVER   = 2'd2;

    localparam logic [3:0] MAX_LEN = 4'd8;

    // Result selection codes issued by the controller.
    localparam logic [1:0] RES_MISS = 2'd0;
    localparam logic [1:0] RES_DUP  = 2'd1;
    localparam logic [1:0] RES_ADD  = 2'd2;
    localparam logic [1:0] RES_HIT  = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [10:0] can_id;
        logic [3:0]  frame_len;
        logic [63:0] frame_data;
        logic [1:0]  bus_channel;
    } t_req;

    typedef struct packed {
        logic              accepted;
        logic [SLOT_W-1:0] slot;
        logic [1:0]        mail_status;
        logic [3:0]        read_len;
        logic [63:0]       read_data;
        logic [1:0]        read_channel;
    } t_res;

    typedef struct packed {
        logic [10:0] can_id;
        logic [3:0]  len;
        logic [63:0] data;
        logic [1:0]  status;
        logic [1:0]  channel;
    } t_entry;

    typedef struct packed {
        logic       load;
        logic       clr_idx;
        logic       inc_idx;
        logic       finish;
        logic [1:0] res_code;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       full;
        logic       drop;
        logic       at_end;
        logic       id_match;
    } t_stat;

    // Mask that covers the low len bytes; len is already limited to 8.
    function automatic logic [63:0] byte_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < len) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

FILE: hdl/can_mbx_ctrl.sv
// Controller of the CAN receive mailbox table: a small state machine that
// sequences the identifier scan. Uses can_mbx_pkg for command and status types.
module can_mbx_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  can_mbx_pkg::t_stat i_stat,
    output can_mbx_pkg::t_cmd  o_cmd,
    output logic               busy
);
    import can_mbx_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_SEARCH = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_IDLE;
                if (i_stat.kind == KIND_ADD && i_stat.full) begin
                    o_cmd.finish   = 1'b1;
                    o_cmd.res_code = RES_MISS;
                end else if (i_stat.kind == KIND_FRAME && i_stat.drop) begin
                    o_cmd.finish   = 1'b1;
                    o_cmd.res_code = RES_MISS;
                end else if (i_stat.kind inside {KIND_ADD, KIND_FRAME, KIND_READ}) begin
                    o_cmd.clr_idx = 1'b1;
                    n_state       = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_stat.at_end) begin
                    o_cmd.finish   = 1'b1;
                    o_cmd.res_code = (i_stat.kind == KIND_ADD) ? RES_ADD : RES_MISS;
                    n_state        = S_IDLE;
                end else if (i_stat.id_match) begin
                    o_cmd.finish   = 1'b1;
                    o_cmd.res_code = (i_stat.kind == KIND_ADD) ? RES_DUP : RES_HIT;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

FILE: hdl/can_mbx_dp.sv
// Datapath of the CAN receive mailbox table: request register, mailbox memory,
// scan index, slot count and result register. Uses can_mbx_pkg.
module can_mbx_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  can_mbx_pkg::t_req  i_req,
    input  can_mbx_pkg::t_cmd  i_cmd,
    output can_mbx_pkg::t_stat o_stat,
    output logic               o_valid,
    output can_mbx_pkg::t_res  o_res
);
    import can_mbx_pkg::*;

    t_req             r_req;
    t_req             w_load;
    t_entry           r_mem [MAILBOX_COUNT];
    t_entry           r_rd;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] n_idx;
    logic [CNT_W-1:0] r_used;
    logic             r_valid;
    t_res             r_res;
    t_res             n_res;
    logic             w_en;
    logic [IDX_W-1:0] w_addr;
    t_entry           w_entry;
    logic [63:0]      w_mask;

    // The length code is limited to eight bytes before the request is registered.
    always_comb begin
        w_load = i_req;
        if (i_req.frame_len > MAX_LEN) begin
            w_load.frame_len = MAX_LEN;
        end
    end

    // Request register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= w_load;
        end
    end

    always_comb begin
        if (i_cmd.clr_idx) begin
            n_idx = '0;
        end else if (i_cmd.inc_idx) begin
            n_idx = CNT_W'(r_idx + 1'b1);
        end else begin
            n_idx = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
    end

    // The read address is taken from n_idx, so r_rd holds entry r_idx while the scan compares it.
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[n_idx[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_entry;
        end
    end

    assign w_mask = byte_mask(r_req.frame_len);

    always_comb begin
        w_en    = 1'b0;
        w_addr  = r_idx[IDX_W-1:0];
        w_entry = r_rd;
        n_res   = '0;
        n_res.slot = SLOT_W'(r_used);
        if (i_cmd.finish) begin
            case (i_cmd.res_code)
                RES_MISS: begin
                end
                RES_DUP: begin
                    n_res.slot = SLOT_W'(r_idx);
                end
                RES_ADD: begin
                    w_en           = 1'b1;
                    w_addr         = r_used[IDX_W-1:0];
                    w_entry        = '0;
                    w_entry.can_id = r_req.can_id;
                    w_entry.status = ST_NODATA;
                    n_res.accepted = 1'b1;
                end
                RES_HIT: begin
                    w_en           = 1'b1;
                    n_res.accepted = 1'b1;
                    n_res.slot     = SLOT_W'(r_idx);
                    if (r_req.kind == KIND_FRAME) begin
                        w_entry.len     = r_req.frame_len;
                        w_entry.data    = (r_rd.data & ~w_mask) | (r_req.frame_data & w_mask);
                        w_entry.channel = r_req.bus_channel;
                        w_entry.status  = (r_rd.status == ST_NEW) ? ST_OVER : ST_NEW;
                        n_res.mail_status = w_entry.status;
                    end else begin
                        w_entry.status     = ST_NODATA;
                        n_res.mail_status  = r_rd.status;
                        n_res.read_len     = r_rd.len;
                        n_res.read_data    = r_rd.data & byte_mask(r_rd.len);
                        n_res.read_channel = r_rd.channel;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cmd.finish && i_cmd.res_code == RES_ADD) begin
                r_used <= CNT_W'(r_used + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_res <= n_res;
        end
    end

    assign o_stat.kind     = r_req.kind;
    assign o_stat.full     = (32'(r_used) >= MAILBOX_COUNT);
    assign o_stat.drop     = (r_req.can_id == DROP_ID) ||
                             (32'(r_req.bus_channel) >= CHANNEL_COUNT);
    assign o_stat.at_end   = (r_idx == r_used);
    assign o_stat.id_match = (r_rd.can_id == r_req.can_id);

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

FILE: hdl/can_receive_mailbox_table.sv
// Top level of the CAN receive mailbox table: joins the controller and the
// datapath. Depends on can_mbx_pkg, can_mbx_ctrl and can_mbx_dp.
//
//  Channel   Ports                   Direction  Handshake
//  request   start, i_req, busy      in         taken when start is high and busy low
//  result    o_valid, o_res          out        one-cycle strobe, cannot be held off
//
// After a request is taken, busy stays high for the decision state and then
// for each mailbox scanned from slot 0. A hit at slot k frees the block once
// slots 0 to k are scanned; a miss, or an add that claims a new slot, scans
// every used slot, of at most 64, before the end of the scan is seen.
// The scan is set by the single read port of the mailbox memory.
// Refused adds to a full table and dropped frames end in the decision state,
// and kind 3 ends there with no result. The result strobe comes in the cycle after
// the deciding cycle, when busy has dropped, so the next request may already be taken then.
// Synchronous reset empties the table; the mailbox memory itself is not
// cleared, since slots are written in full when they are claimed.
module can_receive_mailbox_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  can_mbx_pkg::t_req i_req,
    output logic              busy,
    output logic              o_valid,
    output can_mbx_pkg::t_res o_res
);
    import can_mbx_pkg::*;

    // Command and status between the state machine and the datapath.
    t_cmd  w_cmd;
    t_stat w_stat;

    // The controller only sees status flags: request kind, full table,
    // dropped frame, end of the scan and an identifier match.
    can_mbx_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .busy    (busy)
    );

    // The datapath holds the request, the memory and the result register.
    can_mbx_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

endmodule

FILE: hdl/can_mbx_chk.sv
// Port-level checker for the CAN receive mailbox table, with its bind.
// Depends on can_mbx_pkg and the top level can_receive_mailbox_table.
module can_mbx_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input can_mbx_pkg::t_req i_req,
    input logic              busy,
    input logic              o_valid,
    input can_mbx_pkg::t_res o_res
);
    import can_mbx_pkg::*;

    // A taken request always holds the block for at least its decision cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken without busy");

    // Two results can never be on consecutive cycles.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // A result only follows a busy period.
    a_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a preceding request");

    // Refused or missed requests return no mailbox contents.
    a_miss_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_res.accepted) |->
            (o_res.read_len == 4'd0 && o_res.read_data == 64'd0 &&
             o_res.read_channel == 2'd0 && o_res.mail_status == ST_NODATA))
        else $error("miss result carries data");

    // Returned lengths never exceed eight bytes and the mail status is at most ST_OVER.
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.read_len <= MAX_LEN && o_res.mail_status <= ST_OVER))
        else $error("result field out of range");

endmodule

bind can_receive_mailbox_table can_mbx_chk u_can_mbx_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_req   (i_req),
    .busy    (busy),
    .o_valid (o_valid),
    .o_res   (o_res)
);
